>>> rtl/assert_macros.svh
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define RAU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rau_pkg.sv
// Package: types, codes and constants of the rational arithmetic unit.
package rau_pkg;

  localparam int RAU_WIDTH = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_cmd_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         cmp_result;
    logic [1:0]         status;
  } rau_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MA,
    S_MB,
    S_MC,
    S_COMB,
    S_ABSN,
    S_ABSD,
    S_TWOS,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } rau_state_t;

  typedef struct packed {
    rau_state_t st;
    logic       div_last;
  } rau_ctrl_t;

  typedef struct packed {
    logic bad_in;
    logic skip;
    logic twos_done;
    logic gcd_done;
  } rau_stat_t;

endpackage

>>> rtl/rau_alu.sv
// Shared add/subtract unit of the rational arithmetic unit.
module rau_alu #(
  parameter int AW = 2 * rau_pkg::RAU_WIDTH + 2
) (
  input  logic signed [AW-1:0] a,
  input  logic signed [AW-1:0] b,
  input  logic                 sub,
  output logic signed [AW-1:0] sum
);
  import rau_pkg::*;

  logic signed [AW-1:0] b_inv;

  assign b_inv = sub ? ~b : b;
  assign sum   = a + b_inv + AW'(sub);

endmodule

>>> rtl/rau_ctrl.sv
// Sequencer of the rational arithmetic unit.
module rau_ctrl #(
  parameter int W = rau_pkg::RAU_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rau_pkg::rau_stat_t  stat,
  output rau_pkg::rau_ctrl_t  ctrl,
  output logic                busy,
  output logic                done
);
  import rau_pkg::*;

  localparam int MW = 2 * W;
  localparam int CW = $clog2(MW);

  rau_state_t    state;
  rau_state_t    state_next;
  logic [CW-1:0] cnt;
  logic          div_last;

  assign div_last = (cnt == CW'(MW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FIN);
      if ((state == S_DIVN || state == S_DIVD) && !div_last) begin
        cnt <= cnt + CW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_MA;
      S_MA:   state_next = stat.bad_in ? S_FIN : S_MB;
      S_MB:   state_next = S_MC;
      S_MC:   state_next = S_COMB;
      S_COMB: state_next = S_ABSN;
      S_ABSN: state_next = stat.skip ? S_FIN : S_ABSD;
      S_ABSD: state_next = S_TWOS;
      S_TWOS: if (stat.twos_done) state_next = S_GCD;
      S_GCD:  if (stat.gcd_done) state_next = S_DIVN;
      S_DIVN: if (div_last) state_next = S_DIVD;
      S_DIVD: if (div_last) state_next = S_FIN;
      S_FIN:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state != S_IDLE);
    ctrl.st       = state;
    ctrl.div_last = div_last;
  end

endmodule

>>> rtl/rau_dp.sv
// Datapath of the rational arithmetic unit: products, GCD, divisions, result.
module rau_dp #(
  parameter int W = rau_pkg::RAU_WIDTH
) (
  input  logic               clk,
  input  logic               start,
  input  rau_pkg::rau_cmd_t  cmd,
  input  rau_pkg::rau_ctrl_t ctrl,
  output rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_res_t  result
);
  import rau_pkg::*;

  localparam int MW = 2 * W;
  localparam int AW = MW + 2;
  localparam int HW = MW - W + 1;

  logic [2:0]           op;
  logic signed [W-1:0]  an, ad, bn, bd;
  logic signed [AW-1:0] x, y, z;
  logic [MW-1:0]        u, v, r;
  logic                 neg;

  logic signed [W-1:0]  ma, mb;
  logic signed [MW-1:0] prod;

  logic signed [AW-1:0] alu_a, alu_b, alu_sum;
  logic                 alu_sub;
  logic                 ge;

  logic [MW-1:0]        q;
  logic [MW:0]          t;
  logic [MW-1:0]        r_next;

  logic signed [W-1:0]  nv;
  logic [HW-1:0]        hi_x, hi_z;
  logic                 num_fit, den_fit;
  rau_res_t             res_next;

  rau_alu #(.AW(AW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  // multiplier operand select
  always_comb begin
    ma = an;
    mb = bd;
    unique case (ctrl.st)
      S_MA: begin
        ma = an;
        mb = (op == OP_MUL) ? bn : bd;
      end
      S_MB: begin
        ma = bn;
        mb = ad;
      end
      S_MC: begin
        ma = ad;
        mb = (op == OP_DIV) ? bn : bd;
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  // restoring division step: quotient shifts through x or z
  assign q = (ctrl.st == S_DIVD) ? z[MW-1:0] : x[MW-1:0];
  assign t = {r, q[MW-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (ctrl.st)
      S_COMB: begin
        alu_a   = x;
        alu_b   = y;
        alu_sub = (op != OP_ADD);
      end
      S_ABSN: begin
        alu_b   = x;
        alu_sub = 1'b1;
      end
      S_ABSD: begin
        alu_b   = z;
        alu_sub = 1'b1;
      end
      S_GCD: begin
        alu_a   = AW'(u);
        alu_b   = AW'(v);
        alu_sub = 1'b1;
      end
      S_DIVN, S_DIVD: begin
        alu_a   = AW'(t);
        alu_b   = AW'(u);
        alu_sub = 1'b1;
      end
      S_FIN: begin
        alu_b   = x;
        alu_sub = neg;
      end
      default: ;
    endcase
  end

  assign ge     = !alu_sum[AW-1];
  assign r_next = ge ? alu_sum[MW-1:0] : t[MW-1:0];

  always_comb begin
    stat.bad_in    = (op > OP_CMP) || (ad == '0) || (bd == '0) ||
                     (op == OP_DIV && bn == '0);
    stat.skip      = (op == OP_CMP) || (x == '0);
    stat.twos_done = x[0] | z[0];
    stat.gcd_done  = (u == '0) || (v == '0);
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.st)
      S_IDLE: begin
        if (start) begin
          op <= cmd.op;
          an <= cmd.a_num[W-1:0];
          ad <= cmd.a_den[W-1:0];
          bn <= cmd.b_num[W-1:0];
          bd <= cmd.b_den[W-1:0];
        end
      end
      S_MA: x <= AW'(prod);
      S_MB: y <= AW'(prod);
      S_MC: z <= AW'(prod);
      S_COMB: begin
        if (op == OP_ADD || op == OP_SUB || op == OP_CMP) x <= alu_sum;
      end
      S_ABSN: begin
        if (!stat.skip) begin
          neg <= x[AW-1] ^ z[AW-1];
          if (x[AW-1]) x <= alu_sum;
        end
      end
      S_ABSD: begin
        if (z[AW-1]) z <= alu_sum;
      end
      S_TWOS: begin
        // strip common factors of two before the odd GCD
        if (stat.twos_done) begin
          u <= x[MW-1:0];
          v <= z[MW-1:0];
        end else begin
          x <= x >>> 1;
          z <= z >>> 1;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          u <= (u == '0) ? v : u;
          r <= '0;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (ge) begin
          u <= alu_sum[MW-1:0];
        end else begin
          u <= v;
          v <= u;
        end
      end
      S_DIVN: begin
        x <= AW'({x[MW-2:0], ge});
        r <= ctrl.div_last ? '0 : r_next;
      end
      S_DIVD: begin
        z <= AW'({z[MW-2:0], ge});
        r <= r_next;
      end
      S_FIN: result <= res_next;
      default: ;
    endcase
  end

  // result formatting and range check
  assign nv      = alu_sum[W-1:0];
  assign hi_x    = x[MW-1:W-1];
  assign hi_z    = z[MW-1:W-1];
  assign num_fit = (hi_x == '0) || (neg && hi_x == HW'(1) && x[W-2:0] == '0);
  assign den_fit = (hi_z == '0);

  always_comb begin
    res_next.res_num    = '0;
    res_next.res_den    = 31'd1;
    res_next.cmp_result = CMP_LT;
    res_next.status     = ST_OK;
    priority if (op > OP_CMP) begin
      res_next.status = ST_OK;
    end else if (stat.bad_in) begin
      res_next.status = ST_ZERO;
    end else if (op == OP_CMP) begin
      if (x == '0) begin
        res_next.cmp_result = CMP_EQ;
      end else if (x[AW-1] ^ ad[W-1] ^ bd[W-1]) begin
        res_next.cmp_result = CMP_LT;
      end else begin
        res_next.cmp_result = CMP_GT;
      end
    end else if (x != '0) begin
      if (!(num_fit && den_fit)) begin
        res_next.status = ST_OVF;
      end else begin
        res_next.res_num = 32'(nv);
        res_next.res_den = 31'(z[W-2:0]);
      end
    end
  end

endmodule

>>> rtl/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit: add, subtract, multiply, divide, compare.
// Bad operands finish right after the first product; compare or zero numerator finish after the sign split.
// Arithmetic ops also run the common power-of-two and binary GCD steps, one per cycle;
// the GCD subtract steps use the shared adder.
// One item at a time: busy is high from transfer until done; done pulses one cycle.
// Reset (rst, synchronous) returns the sequencer to idle and clears done.
`include "assert_macros.svh"

module rational_arithmetic_unit_core #(
  parameter int WIDTH = rau_pkg::RAU_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rau_pkg::rau_cmd_t cmd,
  output logic              busy,
  output logic              done,
  output rau_pkg::rau_res_t result
);
  import rau_pkg::*;

  // Flow per item, all on one signed 32x32 multiplier and one shared adder:
  //   MA/MB/MC   three cross products, each registered
  //   COMB       numerator = sum or difference for add/sub (compare: left minus right)
  //   ABSN/ABSD  sign split; compare and zero numerator leave here
  //   TWOS       shift out common factors of two
  //   GCD        binary GCD with subtract, shift and swap steps
  //   DIVN/DIVD  restoring division of numerator and denominator by the GCD,
  //              one quotient bit per cycle
  //   FIN        range check, sign restore, result register load
  rau_ctrl_t ctrl;
  rau_stat_t stat;
  logic      res_zero_one;

  rau_ctrl #(.W(WIDTH)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  rau_dp #(.W(WIDTH)) u_dp (
    .clk    (clk),
    .start  (start),
    .cmd    (cmd),
    .ctrl   (ctrl),
    .stat   (stat),
    .result (result)
  );

  // result fields read 0/1
  assign res_zero_one = (result.res_num == '0) && (result.res_den == 31'd1);

  // done comes from the final state, by which time the sequencer is back at idle
  `RAU_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
  // a transfer always starts the sequencer
  `RAU_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transfer taken but not busy")
  // reduced denominator is never zero
  `RAU_ASSERT_SAME(a_den_nonzero, done, result.res_den != '0, "zero result denominator")
  // error results carry 0/1
  `RAU_ASSERT_SAME(a_err_value, done && result.status != ST_OK, res_zero_one, "error result not 0/1")

endmodule

>>> tb/sv/rational_arithmetic_unit_core_tb.sv
// Testbench for rational_arithmetic_unit_core: directed table and random commands.
module rational_arithmetic_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rau_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_ITEMS  = 1625;
  // slowest legal run: every item at its longest plus a full idle wait, taken
  // several times over
  localparam int CYCLE_LIMIT   = 6_000_000;
  localparam int SETTLE_CYCLES = 500;
  localparam int REPORT_MAX    = 10;

  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;

  // op codes past compare are ignored by the block
  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  // cmp_result reads zero on every non-compare result
  localparam logic [1:0] CMP_NONE = CMP_LT;

  // sign and magnitude, wide enough to hold any cross product or sum of two
  typedef struct packed {
    bit        neg;
    bit [63:0] mag;
  } sign_mag_t;

  typedef struct {
    rau_cmd_t cmd;
    rau_res_t want;
  } owed_result_t;

  typedef struct {
    rau_cmd_t cmd;
    bit       typed;
    rau_res_t golden;
  } directed_row_t;

  logic     clk   = 1'b0;
  logic     rst   = 1'b1;
  logic     start = 1'b0;
  rau_cmd_t cmd   = '0;
  logic     busy;
  logic     done;
  rau_res_t result;

  owed_result_t  pending_results[$];
  directed_row_t directed_rows[$];
  int unsigned   mismatches  = 0;
  int unsigned   cycle_count = 0;

  rational_arithmetic_unit_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fraction predictor
  // ---------------------------------------------------------------------------

  function automatic sign_mag_t to_sign_mag(logic [31:0] raw);
    sign_mag_t r;
    r.neg = raw[31];
    // most negative value keeps magnitude 2^31
    r.mag = {32'd0, raw[31] ? (~raw + 32'd1) : raw};
    return r;
  endfunction

  function automatic sign_mag_t mag_product(sign_mag_t x, sign_mag_t y);
    sign_mag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (r.mag != 0) && (x.neg != y.neg);
    return r;
  endfunction

  function automatic rau_res_t rational_op(rau_cmd_t c);
    sign_mag_t an, ad, bn, bd, lhs, rhs, num, den;
    bit [63:0] x, y, t;
    bit [63:0] half;
    rau_res_t  r;
    r         = '0;
    r.res_den = 31'd1;
    half      = 64'h8000_0000;
    an = to_sign_mag(c.a_num);
    ad = to_sign_mag(c.a_den);
    bn = to_sign_mag(c.b_num);
    bd = to_sign_mag(c.b_den);

    if (c.op > OP_CMP) return r;
    if (ad.mag == 0 || bd.mag == 0 || (c.op == OP_DIV && bn.mag == 0)) begin
      r.status = ST_ZERO;
      return r;
    end

    if (c.op == OP_CMP) begin
      lhs = mag_product(an, bd);
      rhs = mag_product(bn, ad);
      // denominators of opposite sign flip the order
      if (ad.neg != bd.neg) begin
        lhs.neg = (lhs.mag != 0) && !lhs.neg;
        rhs.neg = (rhs.mag != 0) && !rhs.neg;
      end
      if (lhs.neg != rhs.neg)
        r.cmp_result = lhs.neg ? CMP_LT : CMP_GT;
      else if (lhs.mag == rhs.mag)
        r.cmp_result = CMP_EQ;
      else if (lhs.neg)
        r.cmp_result = (lhs.mag > rhs.mag) ? CMP_LT : CMP_GT;
      else
        r.cmp_result = (lhs.mag < rhs.mag) ? CMP_LT : CMP_GT;
      return r;
    end

    case (c.op)
      OP_ADD, OP_SUB: begin
        lhs = mag_product(an, bd);
        rhs = mag_product(bn, ad);
        if (c.op == OP_SUB) rhs.neg = (rhs.mag != 0) && !rhs.neg;
        if (lhs.neg == rhs.neg) begin
          num.mag = lhs.mag + rhs.mag;
          num.neg = lhs.neg;
        end else if (lhs.mag >= rhs.mag) begin
          num.mag = lhs.mag - rhs.mag;
          num.neg = lhs.neg;
        end else begin
          num.mag = rhs.mag - lhs.mag;
          num.neg = rhs.neg;
        end
        den = mag_product(ad, bd);
      end
      OP_MUL: begin
        num = mag_product(an, bn);
        den = mag_product(ad, bd);
      end
      default: begin
        // divide: a times the reciprocal of b
        num = mag_product(an, bd);
        den = mag_product(ad, bn);
      end
    endcase

    if (num.mag == 0) return r;

    x = num.mag;
    y = den.mag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    num.mag = num.mag / x;
    den.mag = den.mag / x;
    num.neg = (num.neg != den.neg);

    if ((num.neg ? (num.mag > half) : (num.mag > half - 1)) || den.mag > half - 1) begin
      r.status = ST_OVF;
      return r;
    end
    r.res_num = num.neg ? (~num.mag[31:0] + 32'd1) : num.mag[31:0];
    r.res_den = den.mag[30:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic row_golden(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd, logic [31:0] rnum,
                            logic [30:0] rden, logic [1:0] rcmp, logic [1:0] rstat);
    directed_row_t row;
    row.cmd                = '{op, an, ad, bn, bd};
    row.typed              = 1'b1;
    row.golden             = '{rnum, rden, rcmp, rstat};
    directed_rows.push_back(row);
  endtask

  task automatic row_model(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    directed_row_t row;
    row.cmd    = '{op, an, ad, bn, bd};
    row.typed  = 1'b0;
    row.golden = '0;
    directed_rows.push_back(row);
  endtask

  // mostly small values so reductions are common, plus wide and corner values
  function automatic logic [31:0] rand_operand();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return 32'($urandom_range(128)) - 32'd64;
    if (roll < 65) return 32'($urandom_range(65535)) - 32'd32768;
    if (roll < 90) return $urandom;
    case ($urandom_range(5))
      0:       return S32_MIN;
      1:       return S32_MAX;
      2:       return '1;
      3:       return 32'd1;
      4:       return S32_MIN + 32'd1;
      default: return '0;
    endcase
  endfunction

  function automatic rau_cmd_t random_cmd();
    rau_cmd_t    c;
    logic [31:0] factor;
    if ($urandom_range(99) < 3)
      c.op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    else
      c.op = 3'($urandom_range(OP_ADD, OP_CMP));
    c.a_num = rand_operand();
    c.a_den = rand_operand();
    c.b_num = rand_operand();
    c.b_den = rand_operand();
    // shared factor gives the GCD loop real work
    if ($urandom_range(3) == 0) begin
      factor  = 32'($urandom_range(2, 999));
      c.a_num = c.a_num * factor;
      c.a_den = c.a_den * factor;
    end
    if ($urandom_range(99) < 3) c.a_den = '0;
    if ($urandom_range(99) < 3) c.b_den = '0;
    if ($urandom_range(99) < 3) c.b_num = '0;
    return c;
  endfunction

  // Sender gap: start drops for a random span, sometimes only after the
  // current item is finished so the gap lands right at the busy edge.
  task automatic maybe_idle(bit allowed);
    int unsigned gap;
    if (allowed && $urandom_range(99) < 36) begin
      start <= 1'b0;
      if ($urandom_range(3) == 0) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds start until a transfer edge (start high, busy low), then records
  // what the result must be. start stays high if the next call follows.
  task automatic issue(rau_cmd_t c, rau_res_t want);
    owed_result_t owed;
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    owed.cmd  = c;
    owed.want = want;
    pending_results.push_back(owed);
  endtask

  // start low until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: done marks a one-cycle result, no back-pressure exists
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    owed_result_t owed;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result num %0d den %0d cmp %0d status %0d", $time,
                   result.res_num, result.res_den, result.cmp_result, result.status);
      end else begin
        owed = pending_results.pop_front();
        if (result.res_num !== owed.want.res_num || result.res_den !== owed.want.res_den ||
            result.cmp_result !== owed.want.cmp_result ||
            result.status !== owed.want.status) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: op %0d a %0d/%0d b %0d/%0d", $time, owed.cmd.op,
                     owed.cmd.a_num, owed.cmd.a_den, owed.cmd.b_num, owed.cmd.b_den);
            $display("  expected num %0d den %0d cmp %0d status %0d",
                     owed.want.res_num, owed.want.res_den, owed.want.cmp_result,
                     owed.want.status);
            $display("  actual   num %0d den %0d cmp %0d status %0d",
                     result.res_num, result.res_den, result.cmp_result, result.status);
          end
        end
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    rau_cmd_t    c;
    rau_res_t    want;
    int unsigned n_counted;
    bit          paused;

    // Directed table. Rows with a typed result are the obvious ones; the rest
    // go through the predictor.
    row_golden(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 32'd5, 31'd6, CMP_NONE, ST_OK);
    row_golden(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 32'd0, 31'd1, CMP_NONE, ST_OK);
    // zero denominators and zero divisor
    row_golden(OP_MUL, 32'd3, 32'd0, 32'd1, 32'd2, 32'd0, 31'd1, CMP_NONE, ST_ZERO);
    row_golden(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd0, 32'd0, 31'd1, CMP_NONE, ST_ZERO);
    row_golden(OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5, 32'd0, 31'd1, CMP_NONE, ST_ZERO);
    row_golden(OP_CMP, 32'd1, 32'd0, 32'd1, 32'd2, 32'd0, 31'd1, CMP_NONE, ST_ZERO);
    // overflow: -2^31 / -1, max + max, denominator past 2^31-1, below -2^31
    row_golden(OP_DIV, S32_MIN, 32'd1, '1, 32'd1, 32'd0, 31'd1, CMP_NONE, ST_OVF);
    row_golden(OP_ADD, S32_MAX, 32'd1, S32_MAX, 32'd1, 32'd0, 31'd1, CMP_NONE, ST_OVF);
    row_golden(OP_MUL, 32'd1, S32_MAX, 32'd1, 32'd2, 32'd0, 31'd1, CMP_NONE, ST_OVF);
    row_golden(OP_SUB, S32_MIN, 32'd1, 32'd1, 32'd1, 32'd0, 31'd1, CMP_NONE, ST_OVF);
    // most negative numerator still fits
    row_golden(OP_MUL, S32_MIN, 32'd1, 32'd1, 32'd1, S32_MIN, 31'd1, CMP_NONE, ST_OK);
    row_golden(OP_ADD, S32_MIN, 32'd1, 32'd0, 32'd1, S32_MIN, 31'd1, CMP_NONE, ST_OK);
    // compare, including a negative denominator
    row_golden(OP_CMP, 32'd1, 32'd2, 32'd2, 32'd4, 32'd0, 31'd1, CMP_EQ, ST_OK);
    row_golden(OP_CMP, -32'sd1, 32'd2, 32'd1, 32'd3, 32'd0, 31'd1, CMP_LT, ST_OK);
    row_golden(OP_CMP, 32'd1, -32'sd2, 32'd1, 32'd3, 32'd0, 31'd1, CMP_LT, ST_OK);
    row_golden(OP_CMP, S32_MAX, 32'd1, S32_MIN, 32'd1, 32'd0, 31'd1, CMP_GT, ST_OK);
    // undefined op codes are ignored even with a zero denominator
    row_golden(OP_UNDEF_LO, 32'd7, 32'd3, 32'd5, 32'd2, 32'd0, 31'd1, CMP_NONE, ST_OK);
    row_golden(OP_UNDEF_HI, '1, 32'd0, '1, 32'd0, 32'd0, 31'd1, CMP_NONE, ST_OK);
    // zero numerator gives 0/1; sign moves off the denominator
    row_golden(OP_MUL, 32'd0, 32'd5, 32'd3, 32'd4, 32'd0, 31'd1, CMP_NONE, ST_OK);
    row_golden(OP_MUL, 32'd3, -32'sd4, 32'd1, 32'd1, -32'sd3, 31'd4, CMP_NONE, ST_OK);
    row_golden(OP_DIV, 32'd6, 32'd1, 32'd3, -32'sd1, -32'sd2, 31'd1, CMP_NONE, ST_OK);
    row_model(OP_ADD, S32_MIN, S32_MIN, 32'd1, 32'd1);
    row_model(OP_SUB, S32_MAX, S32_MIN, S32_MIN, S32_MAX);
    row_model(OP_CMP, S32_MIN, '1, S32_MIN, S32_MIN);
    row_model(OP_CMP, 32'd0, 32'd3, 32'd0, -32'sd7);
    row_model(OP_DIV, '1, '1, '1, '1);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      maybe_idle(1'b1);
      want = directed_rows[i].typed ? directed_rows[i].golden
                                    : rational_op(directed_rows[i].cmd);
      issue(directed_rows[i].cmd, want);
    end
    drain_results();

    // Random part. Ignored op codes don't count toward the item total.
    // Items 500..799 go back to back with no sender gaps.
    n_counted = 0;
    paused    = 1'b0;
    while (n_counted < RANDOM_ITEMS) begin
      if (!paused && n_counted == RANDOM_ITEMS / 2) begin
        drain_results();
        paused = 1'b1;
      end
      c = random_cmd();
      maybe_idle(!(n_counted >= 500 && n_counted < 800));
      issue(c, rational_op(c));
      if (c.op <= OP_CMP) n_counted++;
    end

    drain_results();
    // catch any stray transfer after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
